// ----- hdl/traffic_light_roi_color_classifier_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Traffic light classifier assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_ROI_COLOR_CLASSIFIER_UNIT_MACROS_SVH
`define TRAFFIC_LIGHT_ROI_COLOR_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TLRC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define TLRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tlrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Traffic light classifier package
// Widths, codes and the stage word shared by the classifier modules.
// ----------------------------------------------------------------------------
package tlrc_pkg;

   // Default coordinate width
   localparam int COORD_BITS_DEF = 12;

   // Fixed field widths
   localparam int CHAN_BITS      = 8;
   localparam int RADIUS_BITS    = 6;
   localparam int SIDE_BITS      = RADIUS_BITS + 1;
   localparam int GAP_BITS       = 8;
   localparam int WEIGHT_BITS    = 10;
   localparam int ACC_BITS       = 24;
   localparam int CLASS_BITS     = 2;
   localparam int CSR_INDEX_BITS = 3;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LEFT  = 3'd0,
      CSR_WINDOW_TOP   = 3'd1,
      CSR_LIGHT_RADIUS = 3'd2,
      CSR_LIGHT_GAP    = 3'd3
   } csr_index_type;

   // Light class codes
   typedef enum logic [CLASS_BITS-1:0] {
      CLASS_GREEN  = 2'd0,
      CLASS_YELLOW = 2'd1,
      CLASS_RED    = 2'd2,
      CLASS_ERROR  = 2'd3
   } light_class_type;

   // Word from the window stage to the accumulator stage
   typedef struct packed {
      logic                   last;
      logic [WEIGHT_BITS-1:0] green_w;
      logic [WEIGHT_BITS-1:0] yellow_w;
      logic [WEIGHT_BITS-1:0] red_w;
   } weigh_type;

endpackage

// ----- hdl/tlrc_ifs.sv -----
// ----------------------------------------------------------------------------
// Traffic light classifier channel interfaces
// Pixel request, result response and register write channels.
// ----------------------------------------------------------------------------
interface tlrc_req_if #(
   parameter int COORD_BITS = tlrc_pkg::COORD_BITS_DEF
);
   import tlrc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pix_col;
   logic [COORD_BITS-1:0] pix_row;
   logic [CHAN_BITS-1:0]  blue;
   logic [CHAN_BITS-1:0]  green_ch;
   logic [CHAN_BITS-1:0]  red_ch;
   logic                  frame_end;

   modport source (output valid, pix_col, pix_row, blue, green_ch, red_ch, frame_end,
                   input ready);
   modport sink   (input valid, pix_col, pix_row, blue, green_ch, red_ch, frame_end,
                   output ready);
endinterface

interface tlrc_rsp_if;
   import tlrc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CLASS_BITS-1:0] light_class;
   logic [ACC_BITS-1:0]   green_total;
   logic [ACC_BITS-1:0]   yellow_total;
   logic [ACC_BITS-1:0]   red_total;

   modport source (output valid, light_class, green_total, yellow_total, red_total,
                   input ready);
   modport sink   (input valid, light_class, green_total, yellow_total, red_total,
                   output ready);
endinterface

interface tlrc_csr_if #(
   parameter int COORD_BITS = tlrc_pkg::COORD_BITS_DEF
);
   import tlrc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] reg_index;
   logic [COORD_BITS-1:0]     wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- hdl/tlrc_window_stage.sv -----
// ----------------------------------------------------------------------------
// Traffic light classifier window stage
// Registers the pixel word, tests it against the three windows and forms the
// masked per-window weights into the stage output register.
// ----------------------------------------------------------------------------
module tlrc_window_stage #(
   parameter int COORD_BITS = tlrc_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   tlrc_req_if.sink                         req_port,
   input  logic [COORD_BITS-1:0]            window_left,
   input  logic [COORD_BITS-1:0]            window_top,
   input  logic [tlrc_pkg::RADIUS_BITS-1:0] light_radius,
   input  logic [tlrc_pkg::GAP_BITS-1:0]    light_gap,
   output tlrc_pkg::weigh_type              wt_word,
   output logic                             wt_valid,
   input  logic                             wt_take
);
   import tlrc_pkg::*;

   // Room for top + 4r + 2*gap + side without wrap
   localparam int SPAN_BITS = COORD_BITS + 3;
   localparam int GSUM_BITS = CHAN_BITS + 4;

   // Input register
   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0] col_ff, row_ff;
   logic [CHAN_BITS-1:0]  blue_ff, green_ff, red_ff;
   logic                  last_ff;

   // Stage output register
   weigh_type wt_ff, wt_in;
   logic      wt_valid_ff, wt_valid_in;

   logic                 load_ok;
   logic                 req_take;
   logic [SPAN_BITS-1:0] col_x, row_x, left_x;
   logic [SPAN_BITS-1:0] red_top, yel_top, grn_top;
   logic [SIDE_BITS-1:0] side;
   logic                 col_hit, grn_hit, yel_hit, red_hit;
   logic [GSUM_BITS-1:0] b_x, g_x, r_x;
   logic [GSUM_BITS-1:0] grn_sum, yel_sum, red_sum;

   function automatic logic in_span(input logic [SPAN_BITS-1:0] v,
                                    input logic [SPAN_BITS-1:0] lo,
                                    input logic [SIDE_BITS-1:0] sd);
      logic [SPAN_BITS-1:0] diff;
      diff = v - lo;
      return (v >= lo) && (diff < {{(SPAN_BITS-SIDE_BITS){1'b0}}, sd});
   endfunction

   // Handshake: stage output frees when empty or taken downstream
   assign load_ok        = !wt_valid_ff || wt_take;
   assign req_port.ready = !s1_valid_ff || load_ok;
   assign req_take       = req_port.valid && req_port.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (load_ok) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         col_ff   <= req_port.pix_col;
         row_ff   <= req_port.pix_row;
         blue_ff  <= req_port.blue;
         green_ff <= req_port.green_ch;
         red_ff   <= req_port.red_ch;
         last_ff  <= req_port.frame_end;
      end
   end

   // Window edges
   assign side    = {light_radius, 1'b1};
   assign col_x   = SPAN_BITS'(col_ff);
   assign row_x   = SPAN_BITS'(row_ff);
   assign left_x  = SPAN_BITS'(window_left);
   assign red_top = SPAN_BITS'(window_top);
   assign yel_top = red_top + SPAN_BITS'({light_radius, 1'b0}) + SPAN_BITS'(light_gap);
   assign grn_top = red_top + SPAN_BITS'({light_radius, 2'b00})
                  + SPAN_BITS'({light_gap, 1'b0});

   assign col_hit = in_span(col_x, left_x, side);
   assign grn_hit = col_hit && in_span(row_x, grn_top, side);
   assign yel_hit = col_hit && in_span(row_x, yel_top, side);
   assign red_hit = col_hit && in_span(row_x, red_top, side);

   // Weighted sums
   assign b_x     = GSUM_BITS'(blue_ff);
   assign g_x     = GSUM_BITS'(green_ff);
   assign r_x     = GSUM_BITS'(red_ff);
   assign grn_sum = b_x + (g_x << 3) + r_x;
   assign yel_sum = b_x + (g_x << 1) + (r_x << 1);
   assign red_sum = b_x + g_x + (r_x << 3);

   always_comb begin
      wt_in          = wt_ff;
      wt_valid_in    = wt_valid_ff;
      if (load_ok) begin
         wt_valid_in     = s1_valid_ff;
         wt_in.last      = last_ff;
         wt_in.green_w   = grn_hit ? grn_sum[WEIGHT_BITS+1:2] : '0;
         wt_in.yellow_w  = yel_hit ? yel_sum[WEIGHT_BITS:1]   : '0;
         wt_in.red_w     = red_hit ? red_sum[WEIGHT_BITS+1:2] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_valid_ff <= 1'b0;
      end else begin
         wt_valid_ff <= wt_valid_in;
      end
      wt_ff <= wt_in;
   end

   assign wt_word  = wt_ff;
   assign wt_valid = wt_valid_ff;

endmodule

// ----- hdl/tlrc_accum_stage.sv -----
// ----------------------------------------------------------------------------
// Traffic light classifier accumulator stage
// Adds window weights into three saturating totals; on the frame-end word
// classifies, loads the result register and clears the totals.
// ----------------------------------------------------------------------------
`include "traffic_light_roi_color_classifier_unit_macros.svh"

module tlrc_accum_stage (
   input  logic                clock,
   input  logic                reset,
   input  tlrc_pkg::weigh_type wt_word,
   input  logic                wt_valid,
   output logic                wt_take,
   tlrc_rsp_if.source          rsp_port
);
   import tlrc_pkg::*;

   localparam int SUM_BITS = ACC_BITS + 1;

   logic [ACC_BITS-1:0] grn_acc_ff, grn_acc_in;
   logic [ACC_BITS-1:0] yel_acc_ff, yel_acc_in;
   logic [ACC_BITS-1:0] red_acc_ff, red_acc_in;

   logic                out_valid_ff, out_valid_in;
   light_class_type     class_ff, class_in;
   logic [ACC_BITS-1:0] grn_out_ff, yel_out_ff, red_out_ff;

   logic                out_free;
   logic                emit;
   logic [SUM_BITS-1:0] grn_sum, yel_sum, red_sum;
   logic [ACC_BITS-1:0] grn_sat, yel_sat, red_sat;

   // Check terms
   logic                acc_clear;
   logic                wt_stall;
   logic                rsp_stall;
   logic                show_green;
   logic                green_leads;

   // Result register frees when empty or being taken
   assign out_free = !out_valid_ff || rsp_port.ready;
   assign wt_take  = wt_valid && (!wt_word.last || out_free);
   assign emit     = wt_take && wt_word.last;

   // Saturating adds
   assign grn_sum = SUM_BITS'(grn_acc_ff) + SUM_BITS'(wt_word.green_w);
   assign yel_sum = SUM_BITS'(yel_acc_ff) + SUM_BITS'(wt_word.yellow_w);
   assign red_sum = SUM_BITS'(red_acc_ff) + SUM_BITS'(wt_word.red_w);
   assign grn_sat = grn_sum[ACC_BITS] ? '1 : grn_sum[ACC_BITS-1:0];
   assign yel_sat = yel_sum[ACC_BITS] ? '1 : yel_sum[ACC_BITS-1:0];
   assign red_sat = red_sum[ACC_BITS] ? '1 : red_sum[ACC_BITS-1:0];

   // Accumulator next state
   always_comb begin
      grn_acc_in = grn_acc_ff;
      yel_acc_in = yel_acc_ff;
      red_acc_in = red_acc_ff;
      if (emit) begin
         grn_acc_in = '0;
         yel_acc_in = '0;
         red_acc_in = '0;
      end else if (wt_take) begin
         grn_acc_in = grn_sat;
         yel_acc_in = yel_sat;
         red_acc_in = red_sat;
      end
   end

   // Color decision on the final totals
   always_comb begin
      priority if (grn_sat > yel_sat && grn_sat > red_sat) begin
         class_in = CLASS_GREEN;
      end else if (yel_sat > red_sat && yel_sat >= grn_sat) begin
         class_in = CLASS_YELLOW;
      end else if (red_sat > yel_sat && red_sat >= grn_sat) begin
         class_in = CLASS_RED;
      end else begin
         class_in = CLASS_ERROR;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grn_acc_ff   <= '0;
         yel_acc_ff   <= '0;
         red_acc_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         grn_acc_ff   <= grn_acc_in;
         yel_acc_ff   <= yel_acc_in;
         red_acc_ff   <= red_acc_in;
         out_valid_ff <= out_valid_in;
      end
      if (emit) begin
         class_ff   <= class_in;
         grn_out_ff <= grn_sat;
         yel_out_ff <= yel_sat;
         red_out_ff <= red_sat;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.light_class  = class_ff;
   assign rsp_port.green_total  = grn_out_ff;
   assign rsp_port.yellow_total = yel_out_ff;
   assign rsp_port.red_total    = red_out_ff;

   // Checks
   assign acc_clear   = (grn_acc_ff == '0) && (yel_acc_ff == '0) && (red_acc_ff == '0);
   assign wt_stall    = wt_valid && !wt_take;
   assign rsp_stall   = out_valid_ff && !rsp_port.ready;
   assign show_green  = out_valid_ff && (class_ff == CLASS_GREEN);
   assign green_leads = (grn_out_ff > yel_out_ff) && (grn_out_ff > red_out_ff);

   `TLRC_ASSERT_NEXT(a_emit_shows, clock, reset, emit, out_valid_ff, "frame word lost")
   `TLRC_ASSERT_NEXT(a_emit_clears, clock, reset, emit, acc_clear, "totals not cleared")
   `TLRC_ASSERT_SAME(a_stall_cause, clock, reset, wt_stall, rsp_stall, "stalled without cause")
   `TLRC_ASSERT_SAME(a_green_wins, clock, reset, show_green, green_leads, "green class wrong")

endmodule

// ----- hdl/traffic_light_roi_color_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// Traffic light ROI color classifier
// Sums weighted BGR pixels over three stacked windows per frame and reports
// the three totals with a green, yellow, red or error class.
//
//   channel | dir | per word
//   --------+-----+------------------------------------------------------
//   req     | in  | pixel column, row, blue, green, red, frame end
//   rsp     | out | light class, green, yellow and red totals
//   csr     | in  | register index and write data, always ready
//
// One pixel word per clock sustained while no result waits on rsp; a word passes
// an input register and a weight register, and a frame-end word then loads the
// result register. Results appear only for frame-end words.
// Reset clears the configuration registers, totals and all valid flags.
// While a result waits on rsp, a frame-end word stops in the weight register
// and req stalls once the input register fills behind it.
// ----------------------------------------------------------------------------
module traffic_light_roi_color_classifier_unit #(
   parameter int COORD_BITS = tlrc_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tlrc_req_if.sink   req_port,
   tlrc_rsp_if.source rsp_port,
   tlrc_csr_if.sink   csr_port
);
   import tlrc_pkg::*;

   logic [COORD_BITS-1:0]  left_ff, left_in;
   logic [COORD_BITS-1:0]  top_ff, top_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [GAP_BITS-1:0]    gap_ff, gap_in;

   weigh_type wt_word;
   logic      wt_valid;
   logic      wt_take;

   // Register writes
   assign csr_port.ready = 1'b1;

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      radius_in = radius_ff;
      gap_in    = gap_ff;
      if (csr_port.valid) begin
         unique case (csr_index_type'(csr_port.reg_index))
            CSR_WINDOW_LEFT:  left_in   = csr_port.wdata;
            CSR_WINDOW_TOP:   top_in    = csr_port.wdata;
            CSR_LIGHT_RADIUS: radius_in = csr_port.wdata[RADIUS_BITS-1:0];
            CSR_LIGHT_GAP:    gap_in    = csr_port.wdata[GAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         radius_ff <= '0;
         gap_ff    <= '0;
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         radius_ff <= radius_in;
         gap_ff    <= gap_in;
      end
   end

   tlrc_window_stage #(
      .COORD_BITS (COORD_BITS)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .req_port     (req_port),
      .window_left  (left_ff),
      .window_top   (top_ff),
      .light_radius (radius_ff),
      .light_gap    (gap_ff),
      .wt_word      (wt_word),
      .wt_valid     (wt_valid),
      .wt_take      (wt_take)
   );

   tlrc_accum_stage u_accum (
      .clock    (clock),
      .reset    (reset),
      .wt_word  (wt_word),
      .wt_valid (wt_valid),
      .wt_take  (wt_take),
      .rsp_port (rsp_port)
   );

endmodule

// ----- tb/sv/traffic_light_roi_color_classifier_unit_chk.sv -----
// ----------------------------------------------------------------------------
// Traffic light classifier scoreboard
// Watches the pixel, result and register channels, keeps its own window
// setup and three saturating window sums, and checks every result word
// field by field against the oldest frame summary still owed.
// ----------------------------------------------------------------------------
module traffic_light_roi_color_classifier_unit_chk (
   input  logic clock,
   input  logic reset,
   tlrc_req_if  req_mon,
   tlrc_rsp_if  rsp_mon,
   tlrc_csr_if  csr_mon,
   output int   error_count,
   output int   results_owed
);
   import tlrc_pkg::*;

   localparam int unsigned SUM_LIMIT = (1 << ACC_BITS) - 1;

   // One frame summary as the block should report it
   typedef struct {
      light_class_type     light_class;
      logic [ACC_BITS-1:0] green_total;
      logic [ACC_BITS-1:0] yellow_total;
      logic [ACC_BITS-1:0] red_total;
   } frame_summary_type;

   // Window setup as last written
   logic [COORD_BITS_DEF-1:0] roi_left;
   logic [COORD_BITS_DEF-1:0] roi_top;
   logic [RADIUS_BITS-1:0]    roi_radius;
   logic [GAP_BITS-1:0]       roi_gap;

   // Running window sums
   logic [ACC_BITS-1:0] green_sum;
   logic [ACC_BITS-1:0] yellow_sum;
   logic [ACC_BITS-1:0] red_sum;

   frame_summary_type summaries_owed[$];
   int                mismatches;

   task automatic report(input string msg);
      $display("%0t scoreboard: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [ACC_BITS-1:0] add_clipped(input logic [ACC_BITS-1:0] acc,
                                                       input int unsigned weight);
      int unsigned total;
      total = acc + weight;
      return (total > SUM_LIMIT) ? SUM_LIMIT[ACC_BITS-1:0] : total[ACC_BITS-1:0];
   endfunction

   function automatic bit in_band(input int unsigned v, input int unsigned lo,
                                  input int unsigned side);
      return (v >= lo) && (v < lo + side);
   endfunction

   // Strongest window wins; a tie with green goes to the other color, a yellow-red tie gives error
   function automatic light_class_type classify(input logic [ACC_BITS-1:0] g,
                                                input logic [ACC_BITS-1:0] y,
                                                input logic [ACC_BITS-1:0] r);
      if (g > y && g > r) return CLASS_GREEN;
      if (y > r && y >= g) return CLASS_YELLOW;
      if (r > y && r >= g) return CLASS_RED;
      return CLASS_ERROR;
   endfunction

   // Register write: out-of-range indexes change nothing
   task automatic apply_write();
      case (csr_mon.reg_index)
         CSR_WINDOW_LEFT:  roi_left   = csr_mon.wdata[COORD_BITS_DEF-1:0];
         CSR_WINDOW_TOP:   roi_top    = csr_mon.wdata[COORD_BITS_DEF-1:0];
         CSR_LIGHT_RADIUS: roi_radius = csr_mon.wdata[RADIUS_BITS-1:0];
         CSR_LIGHT_GAP:    roi_gap    = csr_mon.wdata[GAP_BITS-1:0];
         default: ;
      endcase
   endtask

   // Pixel word: add weights into every window it falls in, close frame on end
   task automatic absorb_pixel();
      int unsigned col, row, b, g, r, rad, gap, side;
      int unsigned red_top, yellow_top, green_top;
      frame_summary_type s;
      col  = req_mon.pix_col;
      row  = req_mon.pix_row;
      b    = req_mon.blue;
      g    = req_mon.green_ch;
      r    = req_mon.red_ch;
      rad  = roi_radius;
      gap  = roi_gap;
      side = 2 * rad + 1;
      red_top    = roi_top;
      yellow_top = roi_top + 2 * rad + gap;
      green_top  = roi_top + 4 * rad + 2 * gap;
      if (in_band(col, roi_left, side)) begin
         if (in_band(row, green_top, side))
            green_sum = add_clipped(green_sum, (b + 8 * g + r) >> 2);
         if (in_band(row, yellow_top, side))
            yellow_sum = add_clipped(yellow_sum, (b + 2 * g + 2 * r) >> 1);
         if (in_band(row, red_top, side))
            red_sum = add_clipped(red_sum, (b + g + 8 * r) >> 2);
      end
      if (req_mon.frame_end) begin
         s.light_class  = classify(green_sum, yellow_sum, red_sum);
         s.green_total  = green_sum;
         s.yellow_total = yellow_sum;
         s.red_total    = red_sum;
         summaries_owed = {summaries_owed, s};
         green_sum  = '0;
         yellow_sum = '0;
         red_sum    = '0;
      end
   endtask

   // Result word against the oldest summary owed
   task automatic check_result();
      frame_summary_type want;
      if (summaries_owed.size() == 0) begin
         report($sformatf("result word with no frame pending, class %0d",
                          rsp_mon.light_class));
      end else begin
         want = summaries_owed.pop_front();
         if (rsp_mon.light_class != want.light_class)
            report($sformatf("light_class got %0d expected %0d",
                             rsp_mon.light_class, want.light_class));
         if (rsp_mon.green_total != want.green_total)
            report($sformatf("green_total got %0d expected %0d",
                             rsp_mon.green_total, want.green_total));
         if (rsp_mon.yellow_total != want.yellow_total)
            report($sformatf("yellow_total got %0d expected %0d",
                             rsp_mon.yellow_total, want.yellow_total));
         if (rsp_mon.red_total != want.red_total)
            report($sformatf("red_total got %0d expected %0d",
                             rsp_mon.red_total, want.red_total));
      end
   endtask

   // Results are checked before the same edge's pixel can add a new summary
   always @(posedge clock) begin
      if (reset) begin
         roi_left   = '0;
         roi_top    = '0;
         roi_radius = '0;
         roi_gap    = '0;
         green_sum  = '0;
         yellow_sum = '0;
         red_sum    = '0;
         summaries_owed.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (csr_mon.valid && csr_mon.ready) apply_write();
         if (req_mon.valid && req_mon.ready) absorb_pixel();
      end
      error_count  <= mismatches;
      results_owed <= summaries_owed.size();
   end

   initial mismatches = 0;

endmodule

// ----- tb/sv/traffic_light_roi_color_classifier_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Traffic light classifier testbench
// Drives pixel frames aimed at the three stacked windows under a series of
// window setups, with random idle gaps on both channels and a long
// result-side stall; the scoreboard beside the block checks every result
// word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module traffic_light_roi_color_classifier_unit_tb;
   import tlrc_pkg::*;

   localparam int CB              = COORD_BITS_DEF;
   localparam int COORD_MAX       = (1 << CB) - 1;
   localparam int CHAN_MAX        = (1 << CHAN_BITS) - 1;
   localparam int PHASES          = 8;
   localparam int PHASE_PIXELS    = 148;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int PIPE_SETTLE     = 8;
   localparam int STALL_LIMIT     = 5000;
   localparam int PRESSURE_PHASE  = 3;
   localparam int PAUSE_PHASE     = 4;
   localparam int QUIET_PHASE     = 5;

   // Window setup as the stimulus side sees it
   typedef struct {
      int left;
      int top;
      int radius;
      int gap;
   } roi_setup_type;

   logic          clock;
   logic          reset;
   int            chk_errors;
   int            chk_owed;
   bit            no_idle = 1'b0;
   int            rsp_hold_asked = 0;
   int            rsp_hold_given = 0;
   roi_setup_type roi;

   tlrc_req_if #(.COORD_BITS(CB)) req_if ();
   tlrc_rsp_if                    rsp_if ();
   tlrc_csr_if #(.COORD_BITS(CB)) csr_if ();

   traffic_light_roi_color_classifier_unit #(.COORD_BITS(CB)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   traffic_light_roi_color_classifier_unit_chk scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .csr_mon      (csr_if),
      .error_count  (chk_errors),
      .results_owed (chk_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle span: mostly none or short, now and then long
   function automatic int idle_span();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic int pick_channel();
      int p;
      p = $urandom_range(0, 9);
      if (p == 0) return 0;
      if (p == 1) return CHAN_MAX;
      return $urandom_range(0, CHAN_MAX);
   endfunction

   // One pixel word, held until accepted; valid stays up for the next word
   task automatic send_pixel(input int col, input int row, input int b, input int g,
                             input int r, input bit frame_end);
      int gap;
      gap = idle_span();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.pix_col   <= CB'(col);
      req_if.pix_row   <= CB'(row);
      req_if.blue      <= CHAN_BITS'(b);
      req_if.green_ch  <= CHAN_BITS'(g);
      req_if.red_ch    <= CHAN_BITS'(r);
      req_if.frame_end <= frame_end;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Pixel mostly near one of the windows, sometimes on the frame edges or anywhere
   task automatic send_random_pixel(input bit frame_end);
      int col, row, p, side, band_top, offs_c, offs_r;
      side = 2 * roi.radius + 1;
      p = $urandom_range(0, 99);
      if (p < 75) begin
         case ($urandom_range(0, 2))
            0:       band_top = roi.top;
            1:       band_top = roi.top + 2 * roi.radius + roi.gap;
            default: band_top = roi.top + 4 * roi.radius + 2 * roi.gap;
         endcase
         offs_c = $urandom_range(0, side + 3);
         offs_r = $urandom_range(0, side + 3);
         col = clamp_coord(roi.left + offs_c - 2);
         row = clamp_coord(band_top + offs_r - 2);
      end else if (p < 85) begin
         col = $urandom_range(0, 1) ? COORD_MAX : 0;
         row = $urandom_range(0, 1) ? COORD_MAX : 0;
      end else begin
         col = $urandom_range(0, COORD_MAX);
         row = $urandom_range(0, COORD_MAX);
      end
      send_pixel(col, row, pick_channel(), pick_channel(), pick_channel(), frame_end);
   endtask

   // Frames of random length, each closed by a frame-end word
   task automatic send_random_frames(input int count);
      int sent, len, i;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
         for (i = 0; i < len; i++) send_random_pixel(1'b0);
         send_random_pixel(1'b1);
         sent += len + 1;
      end
   endtask

   // Wait for every owed result, then let the pipeline drain
   task automatic settle_block();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (chk_owed != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= CB'(data);
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // Program all four registers; junk in unused upper bits, sometimes a stray index
   task automatic program_roi(input roi_setup_type s);
      write_reg(CSR_WINDOW_LEFT, s.left);
      write_reg(CSR_WINDOW_TOP, s.top);
      write_reg(CSR_LIGHT_RADIUS, s.radius | ($urandom_range(0, 63) << RADIUS_BITS));
      write_reg(CSR_LIGHT_GAP, s.gap | ($urandom_range(0, 15) << GAP_BITS));
      if ($urandom_range(0, 1))
         write_reg(CSR_INDEX_BITS'($urandom_range((1 << CSR_INDEX_BITS) - 1,
                                                  int'(CSR_LIGHT_GAP) + 1)),
                   $urandom_range(0, COORD_MAX));
      csr_if.valid <= 1'b0;
      roi = s;
   endtask

   // Result side: random readiness, plus a long hold when asked
   initial begin : rsp_sink
      int  span;
      bit  take;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_asked != rsp_hold_given) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_given++;
         end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            take = ($urandom_range(0, 3) != 0);
            rsp_if.ready <= take;
            span = take ? $urandom_range(1, 8) : idle_span() + 1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Watchdog: too long with no word moving on any channel
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("traffic_light_roi_color_classifier_unit_tb: errors");
      $finish;
   end

   initial begin : stimulus
      roi_setup_type plan [PHASES];
      roi_setup_type s;
      int            p;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.pix_col   <= '0;
      req_if.pix_row   <= '0;
      req_if.blue      <= '0;
      req_if.green_ch  <= '0;
      req_if.red_ch    <= '0;
      req_if.frame_end <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.reg_index <= '0;
      csr_if.wdata     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: red rows 20..24, yellow 27..31, green 34..38, columns 10..14
      s = '{left: 10, top: 20, radius: 2, gap: 3};
      program_roi(s);
      send_pixel(0, 0, 0, 0, 0, 1'b1);                      // empty frame
      send_pixel(10, 20, 0, 0, CHAN_MAX, 1'b1);             // red corner
      send_pixel(14, 31, 0, CHAN_MAX, CHAN_MAX, 1'b1);      // yellow far corner
      send_pixel(12, 38, 0, CHAN_MAX, 0, 1'b1);             // green bottom row
      // just outside each edge, then one inside and a frame end off the window
      send_pixel(15, 20, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
      send_pixel(9, 22, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
      send_pixel(12, 19, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
      send_pixel(12, 39, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
      send_pixel(12, 25, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
      send_pixel(14, 24, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b0);
      send_pixel(COORD_MAX, COORD_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1);
      // repeated pixel counts twice
      send_pixel(11, 28, 7, 90, 33, 1'b0);
      send_pixel(11, 28, 7, 90, 33, 1'b0);
      send_pixel(0, COORD_MAX, 0, 0, 0, 1'b1);
      settle_block();

      // Directed: all three windows on the far corner pixel; class ties
      s = '{left: COORD_MAX, top: COORD_MAX, radius: 0, gap: 0};
      program_roi(s);
      send_pixel(COORD_MAX, COORD_MAX, 0, 4, 4, 1'b1);      // green ties red
      send_pixel(COORD_MAX, COORD_MAX, 40, 10, 0, 1'b1);    // yellow ties green
      send_pixel(COORD_MAX, COORD_MAX, 40, 0, 10, 1'b1);    // yellow ties red
      send_pixel(COORD_MAX, COORD_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1);
      send_pixel(COORD_MAX, COORD_MAX, CHAN_MAX, 0, 0, 1'b1);

      // Random phases: the extremes first, one fixed setup, then random setups
      plan[0] = '{left: 0, top: 0, radius: 0, gap: 0};
      plan[1] = '{left: COORD_MAX, top: COORD_MAX, radius: 63, gap: 255};
      plan[2] = '{left: 0, top: 0, radius: 63, gap: 255};
      plan[3] = '{left: 100, top: 50, radius: 3, gap: 2};
      for (p = 4; p < PHASES; p++)
         plan[p] = '{left: $urandom_range(0, COORD_MAX), top: $urandom_range(0, COORD_MAX),
                     radius: $urandom_range(0, 63), gap: $urandom_range(0, 255)};

      for (p = 0; p < PHASES; p++) begin
         settle_block();
         program_roi(plan[p]);
         no_idle = (p == QUIET_PHASE);
         // result side holds off while pixels keep coming
         if (p == PRESSURE_PHASE) rsp_hold_asked++;
         if (p == PAUSE_PHASE) begin
            send_random_frames(PHASE_PIXELS / 2);
            settle_block();
            send_random_frames(PHASE_PIXELS / 2);
         end else begin
            send_random_frames(PHASE_PIXELS);
         end
      end
      no_idle = 1'b0;
      settle_block();

      if (chk_errors == 0)
         $display("traffic_light_roi_color_classifier_unit_tb: clean");
      else
         $display("traffic_light_roi_color_classifier_unit_tb: errors");
      $finish;
   end

endmodule
